### src/rsdz_pkg.sv
// Shared types, constants and field widths of the radial stick dead-zone block.
package rsdz_pkg;

  localparam int COORD_W  = 16;
  localparam int RAD_W    = 15;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Fixed-point widths: magnitude Q16.8, length Q15.8
  localparam int SQ_W     = 32;
  localparam int RADICAND_W = 48;
  localparam int MAG_W    = 24;
  localparam int LEN_W    = 23;
  localparam int LEN_NUM_W = 2 * LEN_W;
  localparam int OUT_NUM_W = COORD_W + LEN_W;
  localparam int OUT_Q_W  = 16;

  localparam logic [RAD_W-1:0] FULL_SCALE = 15'd32767;
  localparam logic [RAD_W-1:0] RADIUS_MAX = 15'd32766;
  localparam logic [LEN_W-1:0] FULL_LEN   = {FULL_SCALE, 8'd0};

  localparam logic [RAD_W-1:0] LEFT_RADIUS_RST  = 15'd7849;
  localparam logic [RAD_W-1:0] RIGHT_RADIUS_RST = 15'd8689;

  // Register indexes
  localparam logic [1:0] REG_CUSTOM_ENABLE = 2'd0;
  localparam logic [1:0] REG_CUSTOM_RADIUS = 2'd1;
  localparam logic [1:0] REG_LEFT_RADIUS   = 2'd2;
  localparam logic [1:0] REG_RIGHT_RADIUS  = 2'd3;

  typedef struct packed {
    logic                      stick_select;
    logic signed [COORD_W-1:0] raw_x;
    logic signed [COORD_W-1:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] adjusted_x;
    logic signed [COORD_W-1:0] adjusted_y;
  } out_item_t;

  typedef struct packed {
    logic             custom_enable;
    logic [RAD_W-1:0] custom_radius;
    logic [RAD_W-1:0] left_default_radius;
    logic [RAD_W-1:0] right_default_radius;
  } cfg_regs_t;

endpackage

### src/rsdz_cfg.sv
// Configuration register file with APB-style access and radius clamping.
module rsdz_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsdz_pkg::ADDR_W-1:0] paddr,
  input  logic [rsdz_pkg::DATA_W-1:0] pwdata,
  output logic [rsdz_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rsdz_pkg::cfg_regs_t         regs
);
  import rsdz_pkg::*;

  cfg_regs_t        regs_r;
  logic             wr_en;
  logic [1:0]       idx;
  logic [RAD_W-1:0] rad_clamped;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Saturate a written radius at the largest legal value
  assign rad_clamped = (pwdata[RAD_W-1:0] > RADIUS_MAX) ? RADIUS_MAX : pwdata[RAD_W-1:0];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.custom_enable        <= 1'b0;
      regs_r.custom_radius        <= '0;
      regs_r.left_default_radius  <= LEFT_RADIUS_RST;
      regs_r.right_default_radius <= RIGHT_RADIUS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CUSTOM_ENABLE: regs_r.custom_enable        <= pwdata[0];
        REG_CUSTOM_RADIUS: regs_r.custom_radius        <= rad_clamped;
        REG_LEFT_RADIUS:   regs_r.left_default_radius  <= rad_clamped;
        REG_RIGHT_RADIUS:  regs_r.right_default_radius <= rad_clamped;
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_CUSTOM_ENABLE: prdata = {{(DATA_W-1){1'b0}}, regs_r.custom_enable};
      REG_CUSTOM_RADIUS: prdata = {{(DATA_W-RAD_W){1'b0}}, regs_r.custom_radius};
      REG_LEFT_RADIUS:   prdata = {{(DATA_W-RAD_W){1'b0}}, regs_r.left_default_radius};
      REG_RIGHT_RADIUS:  prdata = {{(DATA_W-RAD_W){1'b0}}, regs_r.right_default_radius};
      default:           prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

### src/rsdz_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module rsdz_sqrt #(
  parameter int RW = 48,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [RW-1:0]   radicand,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW/2-1:0] root,
  output logic [SW-1:0]   side_out
);
  localparam int QW  = RW / 2;
  localparam int RMW = QW + 2;

  logic           vld  [0:QW];
  logic [RMW-1:0] rem  [0:QW];
  logic [QW-1:0]  rt   [0:QW];
  logic [RW-1:0]  low  [0:QW];
  logic [SW-1:0]  side [0:QW];

  // Load the first stage
  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    rt[0]   = '0;
    low[0]  = radicand;
    side[0] = side_in;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem[k][RMW-3:0], low[k][RW-1:RW-2]};
    assign trial  = {rt[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        rt[k+1]   <= {rt[k][QW-2:0], ge};
        low[k+1]  <= {low[k][RW-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign root      = rt[QW];
  assign side_out  = side[QW];

endmodule

### src/rsdz_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rsdz_div #(
  parameter int NW = 46,
  parameter int DW = 23,
  parameter int QW = 23,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);
  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] dv   [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [SW-1:0] side [0:QW];

  // Load the first stage; the upper numerator part is below the divisor
  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = DW'(num >> QW);
    dv[0]   = den;
    low[0]  = num[QW-1:0];
    q[0]    = '0;
    side[0] = side_in;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // Shift in the next numerator bit and subtract when it fits
    assign trial = {rem[k], low[k][QW-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign ge    = trial >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        dv[k+1]   <= dv[k];
        low[k+1]  <= {low[k][QW-2:0], 1'b0};
        q[k+1]    <= {q[k][QW-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign side_out  = side[QW];

endmodule

### src/radial_stick_dead_zone.sv
// Top level: radial dead-zone rescaling pipeline for analog stick samples.
//
// Accepts one (x, y) stick sample per clock and returns one rescaled sample per
// clock when not stalled, passing through the input stage, squaring, a 24-stage
// square root, a radius compare, a length multiply, a 23-stage length divider,
// a coordinate multiply, two 16-stage coordinate dividers and the output
// register. The whole pipeline holds as one while a result waits at the output
// and out_ready is low; in_ready is high whenever the output register is empty
// or being taken. Registers are written through the APB-style port at byte
// addresses 0, 4, 8 and 12 and must only change while no sample is in flight.
module radial_stick_dead_zone (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rsdz_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rsdz_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsdz_pkg::ADDR_W-1:0] paddr,
  input  logic [rsdz_pkg::DATA_W-1:0] pwdata,
  output logic [rsdz_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rsdz_pkg::*;

  localparam int SQRT_SW = 2 + 2 * COORD_W + RAD_W;
  localparam int DIV_SW  = 2 + MAG_W + 2 + 2 * COORD_W;

  cfg_regs_t regs;
  logic      en;

  rsdz_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  logic out_valid_r;
  out_item_t out_data_r;

  // Advance everything unless a finished result is held at the output
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: absolute values, signs and radius
  logic [COORD_W-1:0] x_u, y_u, ax_nxt, ay_nxt;
  logic [RAD_W-1:0]   r_nxt;
  logic               v1_r, sx1_r, sy1_r;
  logic [COORD_W-1:0] ax1_r, ay1_r;
  logic [RAD_W-1:0]   r1_r;

  assign x_u    = in_data.raw_x;
  assign y_u    = in_data.raw_y;
  assign ax_nxt = x_u[COORD_W-1] ? (~x_u + 1'b1) : x_u;
  assign ay_nxt = y_u[COORD_W-1] ? (~y_u + 1'b1) : y_u;
  assign r_nxt  = regs.custom_enable ? regs.custom_radius :
                  (in_data.stick_select ? regs.right_default_radius
                                        : regs.left_default_radius);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1_r <= x_u[COORD_W-1];
      sy1_r <= y_u[COORD_W-1];
      ax1_r <= ax_nxt;
      ay1_r <= ay_nxt;
      r1_r  <= r_nxt;
    end
  end

  // Stage 2: squares
  logic              v2_r, sx2_r, sy2_r;
  logic [COORD_W-1:0] ax2_r, ay2_r;
  logic [RAD_W-1:0]  r2_r;
  logic [SQ_W-1:0]   sqx2_r, sqy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2_r <= {16'd0, ax1_r} * {16'd0, ax1_r};
      sqy2_r <= {16'd0, ay1_r} * {16'd0, ay1_r};
      sx2_r  <= sx1_r;
      sy2_r  <= sy1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      r2_r   <= r1_r;
    end
  end

  // Square root of the scaled sum of squares
  logic [SQ_W-1:0]    sum_sq;
  logic               v3;
  logic [MAG_W-1:0]   mag3;
  logic [SQRT_SW-1:0] side3;

  assign sum_sq = sqx2_r + sqy2_r;

  rsdz_sqrt #(.RW(RADICAND_W), .SW(SQRT_SW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .radicand  ({sum_sq, 16'd0}),
    .side_in   ({sx2_r, sy2_r, ax2_r, ay2_r, r2_r}),
    .out_valid (v3),
    .root      (mag3),
    .side_out  (side3)
  );

  // Stage 4: dead-zone and clip tests, length terms
  logic               sx3, sy3;
  logic [COORD_W-1:0] ax3, ay3;
  logic [RAD_W-1:0]   r3;
  logic [LEN_W-1:0]   r8;
  logic               zero_nxt, clip_nxt;
  logic [LEN_W-1:0]   diff_nxt;

  assign {sx3, sy3, ax3, ay3, r3} = side3;
  assign r8       = {r3, 8'd0};
  assign zero_nxt = mag3 <= {1'b0, r8};
  assign clip_nxt = mag3 > {1'b0, FULL_LEN};
  assign diff_nxt = (zero_nxt || clip_nxt) ? '0 : LEN_W'(mag3 - {1'b0, r8});

  logic               v4_r, zero4_r, clip4_r, sx4_r, sy4_r;
  logic [MAG_W-1:0]   mag4_r;
  logic [LEN_W-1:0]   diff4_r, den4_r;
  logic [COORD_W-1:0] ax4_r, ay4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero4_r <= zero_nxt;
      clip4_r <= clip_nxt;
      mag4_r  <= mag3;
      diff4_r <= diff_nxt;
      den4_r  <= {FULL_SCALE - r3, 8'd0};
      sx4_r   <= sx3;
      sy4_r   <= sy3;
      ax4_r   <= ax3;
      ay4_r   <= ay3;
    end
  end

  // Stage 5: length numerator mag * (mag - R)
  logic                 v5_r, zero5_r, clip5_r, sx5_r, sy5_r;
  logic [MAG_W-1:0]     mag5_r;
  logic [LEN_NUM_W-1:0] num5_r;
  logic [LEN_W-1:0]     den5_r;
  logic [COORD_W-1:0]   ax5_r, ay5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5_r  <= {{LEN_W{1'b0}}, mag4_r[LEN_W-1:0]} * {{LEN_W{1'b0}}, diff4_r};
      den5_r  <= den4_r;
      zero5_r <= zero4_r;
      clip5_r <= clip4_r;
      mag5_r  <= mag4_r;
      sx5_r   <= sx4_r;
      sy5_r   <= sy4_r;
      ax5_r   <= ax4_r;
      ay5_r   <= ay4_r;
    end
  end

  // Divide for the new length
  logic              v6;
  logic [LEN_W-1:0]  len_q;
  logic [DIV_SW-1:0] side6;

  rsdz_div #(.NW(LEN_NUM_W), .DW(LEN_W), .QW(LEN_W), .SW(DIV_SW)) u_len_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .num       (num5_r),
    .den       (den5_r),
    .side_in   ({zero5_r, clip5_r, mag5_r, sx5_r, sy5_r, ax5_r, ay5_r}),
    .out_valid (v6),
    .quo       (len_q),
    .side_out  (side6)
  );

  // Stage 7: final length and coordinate numerators
  logic               zero6, clip6, sx6, sy6;
  logic [MAG_W-1:0]   mag6;
  logic [COORD_W-1:0] ax6, ay6;
  logic [LEN_W-1:0]   len6;

  assign {zero6, clip6, mag6, sx6, sy6, ax6, ay6} = side6;
  assign len6 = clip6 ? FULL_LEN : len_q;

  logic                 v7_r, sx7_r, sy7_r;
  logic [OUT_NUM_W-1:0] nx7_r, ny7_r;
  logic [MAG_W-1:0]     dv7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx7_r <= {{LEN_W{1'b0}}, ax6} * {{COORD_W{1'b0}}, len6};
      ny7_r <= {{LEN_W{1'b0}}, ay6} * {{COORD_W{1'b0}}, len6};
      dv7_r <= zero6 ? MAG_W'(1) : mag6;
      sx7_r <= sx6;
      sy7_r <= sy6;
    end
  end

  // Divide each coordinate by the magnitude
  logic               v8x, v8y, sx8, sy8;
  logic [OUT_Q_W-1:0] qx8, qy8;

  rsdz_div #(.NW(OUT_NUM_W), .DW(MAG_W), .QW(OUT_Q_W), .SW(1)) u_x_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .num       (nx7_r),
    .den       (dv7_r),
    .side_in   (sx7_r),
    .out_valid (v8x),
    .quo       (qx8),
    .side_out  (sx8)
  );

  rsdz_div #(.NW(OUT_NUM_W), .DW(MAG_W), .QW(OUT_Q_W), .SW(1)) u_y_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .num       (ny7_r),
    .den       (dv7_r),
    .side_in   (sy7_r),
    .out_valid (v8y),
    .quo       (qy8),
    .side_out  (sy8)
  );

  // Output register: restore signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v8x && v8y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.adjusted_x <= sx8 ? (~qx8 + 1'b1) : qx8;
      out_data_r.adjusted_y <= sy8 ? (~qy8 + 1'b1) : qy8;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the radial stick dead-zone pipeline.
`timescale 1ns / 1ps

module tb_top;
  import rsdz_pkg::*;

  localparam int LATENCY   = 69;
  localparam int MAX_CYCLE = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Idle pacing, in percent; hold_off forces a long receiver stall
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // Shadow copy of the block's registers
  logic custom_en_q;
  logic [RAD_W-1:0] custom_rad_q, left_rad_q, right_rad_q;

  in_item_t pending_samples[$];
  out_item_t expected_samples[$];

  radial_stick_dead_zone u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // floor(sqrt(v))
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_axis(input logic signed [15:0] c,
                                             input logic [63:0] len8,
                                             input logic [63:0] mag8);
    logic [63:0] mag_c, q;
    mag_c = c[15] ? (64'd65536 - {48'd0, c}) : {48'd0, c};
    q = (mag_c * len8) / mag8;
    if (c[15]) q = 64'd0 - q;
    return q[15:0];
  endfunction

  function automatic out_item_t predict_dead_zone(input in_item_t s);
    out_item_t r;
    logic [RAD_W-1:0] rad;
    logic [63:0] ax, ay, mag8, r8, len8;
    rad = custom_en_q ? custom_rad_q : (s.stick_select ? right_rad_q : left_rad_q);
    ax = s.raw_x[15] ? (64'd65536 - {48'd0, s.raw_x}) : {48'd0, s.raw_x};
    ay = s.raw_y[15] ? (64'd65536 - {48'd0, s.raw_y}) : {48'd0, s.raw_y};
    mag8 = floor_sqrt((ax * ax + ay * ay) << 16);
    r8 = {49'd0, rad} << 8;
    r = '0;
    if (mag8 > r8) begin
      if (mag8 > (64'd32767 << 8)) len8 = 64'd32767 << 8;
      else len8 = (mag8 * (mag8 - r8)) / ((64'd32767 - rad) << 8);
      r.adjusted_x = scale_axis(s.raw_x, len8, mag8);
      r.adjusted_y = scale_axis(s.raw_y, len8, mag8);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what,
             $signed(got), $signed(want), cycle_count);
    err_count++;
  endtask

  // Drive the sample stream: hold valid until the transaction completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict at acceptance, in order
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_samples.push_back(predict_dead_zone(in_data));
  end

  // Receiver pacing, with an optional long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        err_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_data.adjusted_x !== want.adjusted_x)
          report_mismatch("adjusted_x", out_data.adjusted_x, want.adjusted_x);
        if (out_data.adjusted_y !== want.adjusted_y)
          report_mismatch("adjusted_y", out_data.adjusted_y, want.adjusted_y);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CUSTOM_ENABLE: custom_en_q = value[0];
      REG_CUSTOM_RADIUS: custom_rad_q = (value[14:0] > RADIUS_MAX) ? RADIUS_MAX : value[14:0];
      REG_LEFT_RADIUS:   left_rad_q = (value[14:0] > RADIUS_MAX) ? RADIUS_MAX : value[14:0];
      default:           right_rad_q = (value[14:0] > RADIUS_MAX) ? RADIUS_MAX : value[14:0];
    endcase
  endtask

  task automatic drain_pipeline();
    while (pending_samples.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic in_item_t make_sample(input logic sel, input int x, input int y);
    in_item_t s;
    s.stick_select = sel;
    s.raw_x = 16'(x);
    s.raw_y = 16'(y);
    return s;
  endfunction

  // Random sample: mix of full range, near-radius, small and extreme-x vectors
  function automatic in_item_t rand_sample();
    in_item_t s;
    int unsigned kind;
    s.stick_select = 1'($urandom_range(1));
    kind = $urandom_range(3);
    case (kind)
      0: begin
        s.raw_x = 16'($urandom);
        s.raw_y = 16'($urandom);
      end
      1: begin
        s.raw_x = 16'($signed($urandom_range(20000)) - 10000);
        s.raw_y = 16'($signed($urandom_range(20000)) - 10000);
      end
      2: begin
        s.raw_x = 16'($signed($urandom_range(64)) - 32);
        s.raw_y = 16'($signed($urandom_range(64)) - 32);
      end
      default: begin
        s.raw_x = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        s.raw_y = 16'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic run_random(input int n, input int unsigned src, input int unsigned snk);
    src_idle_pct = src;
    snk_stall_pct = snk;
    for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample());
    drain_pipeline();
  endtask

  initial begin
    custom_en_q = 1'b0;
    custom_rad_q = '0;
    left_rad_q = LEFT_RADIUS_RST;
    right_rad_q = RIGHT_RADIUS_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset radii, extremes, zero magnitude, dead-zone edges
    pending_samples.push_back(make_sample(0, 0, 0));
    pending_samples.push_back(make_sample(1, 0, 0));
    pending_samples.push_back(make_sample(0, 32767, 0));
    pending_samples.push_back(make_sample(0, -32768, 0));
    pending_samples.push_back(make_sample(1, 0, -32768));
    pending_samples.push_back(make_sample(1, -32768, -32768));
    pending_samples.push_back(make_sample(0, 32767, 32767));
    pending_samples.push_back(make_sample(0, 7849, 0));
    pending_samples.push_back(make_sample(0, 7850, 0));
    pending_samples.push_back(make_sample(1, 0, 8689));
    pending_samples.push_back(make_sample(1, 0, 8690));
    pending_samples.push_back(make_sample(0, 5550, -5550));
    pending_samples.push_back(make_sample(1, -20000, 15000));
    pending_samples.push_back(make_sample(0, -1, 1));
    pending_samples.push_back(make_sample(1, 23170, 23170));
    drain_pipeline();

    // Custom radius zero, then saturating writes and all-ones unused bits
    write_reg(REG_CUSTOM_ENABLE, 32'hffff_fffe);
    write_reg(REG_CUSTOM_RADIUS, 32'd0);
    write_reg(REG_CUSTOM_ENABLE, 32'd1);
    pending_samples.push_back(make_sample(0, 1, 0));
    pending_samples.push_back(make_sample(1, -1, -1));
    pending_samples.push_back(make_sample(0, 32767, -32768));
    run_random(60, 0, 0);

    write_reg(REG_CUSTOM_RADIUS, 32'hffff_ffff);
    pending_samples.push_back(make_sample(0, 32766, 0));
    pending_samples.push_back(make_sample(1, 32767, 0));
    pending_samples.push_back(make_sample(0, -32768, 1));
    run_random(40, 45, 0);

    write_reg(REG_CUSTOM_ENABLE, 32'd0);
    write_reg(REG_LEFT_RADIUS, 32'd0);
    write_reg(REG_RIGHT_RADIUS, 32'h0000_7fff);
    run_random(100, 0, 45);

    write_reg(REG_LEFT_RADIUS, 32'd20000);
    write_reg(REG_RIGHT_RADIUS, 32'd100);
    run_random(100, 19, 19);

    // Long receiver hold-off while the sender keeps offering
    write_reg(REG_CUSTOM_ENABLE, 32'd1);
    write_reg(REG_CUSTOM_RADIUS, 32'd12345);
    hold_off = 300;
    run_random(100, 0, 0);

    write_reg(REG_LEFT_RADIUS, 32'd7849);
    write_reg(REG_CUSTOM_ENABLE, 32'd0);
    run_random(100, 45, 45);

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
